FILE: sv/binary_tone_detector_dft_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the single-bin tone detector.
// All macros sample on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef BINARY_TONE_DETECTOR_DFT_MACROS_SVH
`define BINARY_TONE_DETECTOR_DFT_MACROS_SVH

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define BTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone detector check failed");

// Checks a same-cycle implication (which may carry its own delay), outside reset.
`define BTD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone detector check failed");

// Checks a next-cycle implication that also holds while reset is applied.
`define BTD_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tone detector reset check failed");

`endif

FILE: sv/btd_pkg.sv
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types, constants and twiddle tables of the single-bin tone detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btd_pkg;

  // Default capture length in samples.
  localparam int NUM_SAMPLES_DEF = 40;

  // Twiddle coefficients are scaled by this factor.
  localparam int TW_SCALE = 100;

  // Width of a twiddle coefficient (signed).
  localparam int TW_W = 8;

  // Output magnitude width.
  localparam int MAG_W = 13;

  // Table periods and the index widths that cover them.
  localparam int PERIOD10 = 10;
  localparam int P10_W    = 4;
  localparam int P8_W     = 3;

  // Tone select codes.
  localparam logic TONE_100HZ = 1'b0;
  localparam logic TONE_125HZ = 1'b1;

  // One accepted input beat.
  typedef struct packed {
    logic start_req;
    logic pin_level;
  } btd_item_t;

  // Twiddle coefficient pair.
  typedef struct packed {
    logic signed [TW_W-1:0] re;
    logic signed [TW_W-1:0] im;
  } btd_tw_t;

  // Period-10 table for the 100 Hz tone.
  function automatic btd_tw_t tw10(input logic [P10_W-1:0] idx);
    btd_tw_t t;
    unique case (idx)
      4'd0:    begin t.re =  8'sd100; t.im =  8'sd0;  end
      4'd1:    begin t.re =  8'sd81;  t.im = -8'sd59; end
      4'd2:    begin t.re =  8'sd31;  t.im = -8'sd95; end
      4'd3:    begin t.re = -8'sd31;  t.im = -8'sd95; end
      4'd4:    begin t.re = -8'sd81;  t.im = -8'sd59; end
      4'd5:    begin t.re = -8'sd100; t.im =  8'sd0;  end
      4'd6:    begin t.re = -8'sd81;  t.im =  8'sd59; end
      4'd7:    begin t.re = -8'sd31;  t.im =  8'sd95; end
      4'd8:    begin t.re =  8'sd31;  t.im =  8'sd95; end
      4'd9:    begin t.re =  8'sd81;  t.im =  8'sd59; end
      default: begin t.re =  8'sd0;   t.im =  8'sd0;  end
    endcase
    return t;
  endfunction

  // Period-8 table for the 125 Hz tone.
  function automatic btd_tw_t tw8(input logic [P8_W-1:0] idx);
    btd_tw_t t;
    unique case (idx)
      3'd0: begin t.re =  8'sd100; t.im =  8'sd0;   end
      3'd1: begin t.re =  8'sd71;  t.im = -8'sd71;  end
      3'd2: begin t.re =  8'sd0;   t.im = -8'sd100; end
      3'd3: begin t.re = -8'sd71;  t.im = -8'sd71;  end
      3'd4: begin t.re = -8'sd100; t.im =  8'sd0;   end
      3'd5: begin t.re = -8'sd71;  t.im =  8'sd71;  end
      3'd6: begin t.re =  8'sd0;   t.im =  8'sd100; end
      3'd7: begin t.re =  8'sd71;  t.im =  8'sd71;  end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/binary_tone_detector_dft.sv
// ----------------------------------------------------------------------------
// binary_tone_detector_dft
// Single-bin DFT tone detector over one-bit pin samples.
// ----------------------------------------------------------------------------
// The block accepts one input beat per clock cycle while in_ready is high. Each
// beat is either a start request, which opens a new capture and clears the sums,
// or one pin sample that, when the pin is high, adds the twiddle of the selected
// tone to the real and imaginary sums. After NUM_SAMPLES samples, the next beat
// closes the capture and yields one magnitude beat, |real| + |imag|, saturated
// to 13 bits. A beat passes an input register and then a single accumulate step
// into the output register. The output register stalls the input side only while a
// result waits and out_ready is low.
// tone_select should be written only while no capture is in progress.
`timescale 1ns / 1ps
`default_nettype none

module binary_tone_detector_dft #(
  parameter int NUM_SAMPLES = btd_pkg::NUM_SAMPLES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic                     cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     start_req,
  input  wire logic                     pin_level,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [btd_pkg::MAG_W-1:0]     magnitude
);

  logic                          tone_select;
  logic                          s1_valid;
  btd_pkg::btd_item_t            s1_item;
  logic                          advance;
  logic                          res_fire;
  logic [btd_pkg::MAG_W-1:0]     res_mag;

  // The input stage moves on whenever the output register is free or emptying.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_select <= btd_pkg::TONE_100HZ;
    end else if (cfg_write) begin
      tone_select <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.start_req <= start_req;
      s1_item.pin_level <= pin_level;
    end
  end

  // Capture state and accumulators.
  btd_core #(
    .NUM_SAMPLES (NUM_SAMPLES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_valid && advance),
    .item     (s1_item),
    .tone_sel (tone_select),
    .res_fire (res_fire),
    .res_mag  (res_mag)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      magnitude <= res_mag;
    end
  end

endmodule

`default_nettype wire

FILE: sv/btd_twiddle.sv
// ----------------------------------------------------------------------------
// btd_twiddle
// Selects the twiddle coefficient pair for the current sample index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btd_twiddle (
  input  wire logic                       tone_sel,
  input  wire logic [btd_pkg::P10_W-1:0]  idx10,
  input  wire logic [btd_pkg::P8_W-1:0]   idx8,
  output btd_pkg::btd_tw_t                tw
);

  // Pick the table of the selected tone.
  always_comb begin
    unique case (tone_sel)
      btd_pkg::TONE_125HZ: tw = btd_pkg::tw8(idx8);
      default:             tw = btd_pkg::tw10(idx10);
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/btd_core.sv
// ----------------------------------------------------------------------------
// btd_core
// Capture state, sample counters and the real and imaginary accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btd_core #(
  parameter int NUM_SAMPLES = btd_pkg::NUM_SAMPLES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire btd_pkg::btd_item_t        item,
  input  wire logic                      tone_sel,
  output logic                           res_fire,
  output logic [btd_pkg::MAG_W-1:0]      res_mag
);

  localparam int CNT_W = $clog2(NUM_SAMPLES + 1);
  localparam int SUM_W = $clog2(NUM_SAMPLES * btd_pkg::TW_SCALE + 1) + 1;
  localparam int MW    = (SUM_W + 1 > btd_pkg::MAG_W) ? SUM_W + 1 : btd_pkg::MAG_W;

  logic                        capturing, capturing_next;
  logic [CNT_W-1:0]            sample_count, sample_count_next;
  logic [btd_pkg::P10_W-1:0]   idx10, idx10_next;
  logic signed [SUM_W-1:0]     real_sum, real_sum_next;
  logic signed [SUM_W-1:0]     imag_sum, imag_sum_next;
  btd_pkg::btd_tw_t            tw;
  logic                        done;
  logic [SUM_W-1:0]            abs_re, abs_im;
  logic [MW-1:0]               mag_wide;

  // Twiddle at the current sample index.
  btd_twiddle u_twiddle (
    .tone_sel (tone_sel),
    .idx10    (idx10),
    .idx8     (sample_count[btd_pkg::P8_W-1:0]),
    .tw       (tw)
  );

  // The capture is complete once all samples are in.
  assign done = (sample_count >= CNT_W'(NUM_SAMPLES));

  // Magnitude estimate |real| + |imag|, saturated to the output range.
  always_comb begin
    abs_re   = real_sum[SUM_W-1] ? $unsigned(-real_sum) : $unsigned(real_sum);
    abs_im   = imag_sum[SUM_W-1] ? $unsigned(-imag_sum) : $unsigned(imag_sum);
    mag_wide = MW'(abs_re) + MW'(abs_im);
    if (mag_wide > MW'({btd_pkg::MAG_W{1'b1}})) begin
      res_mag = {btd_pkg::MAG_W{1'b1}};
    end else begin
      res_mag = btd_pkg::MAG_W'(mag_wide);
    end
  end

  // Next-state logic for one processed beat.
  always_comb begin
    capturing_next    = capturing;
    sample_count_next = sample_count;
    idx10_next        = idx10;
    real_sum_next     = real_sum;
    imag_sum_next     = imag_sum;
    res_fire          = 1'b0;
    if (step) begin
      priority if (item.start_req) begin
        capturing_next    = 1'b1;
        sample_count_next = '0;
        idx10_next        = '0;
        real_sum_next     = '0;
        imag_sum_next     = '0;
      end else if (capturing && done) begin
        capturing_next    = 1'b0;
        sample_count_next = '0;
        idx10_next        = '0;
        res_fire          = 1'b1;
      end else if (capturing) begin
        if (item.pin_level) begin
          real_sum_next = real_sum + SUM_W'(tw.re);
          imag_sum_next = imag_sum + SUM_W'(tw.im);
        end
        sample_count_next = sample_count + CNT_W'(1);
        if (idx10 == btd_pkg::P10_W'(btd_pkg::PERIOD10 - 1)) begin
          idx10_next = '0;
        end else begin
          idx10_next = idx10 + btd_pkg::P10_W'(1);
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capturing    <= 1'b0;
      sample_count <= '0;
      idx10        <= '0;
      real_sum     <= '0;
      imag_sum     <= '0;
    end else begin
      capturing    <= capturing_next;
      sample_count <= sample_count_next;
      idx10        <= idx10_next;
      real_sum     <= real_sum_next;
      imag_sum     <= imag_sum_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/btd_checker.sv
// ----------------------------------------------------------------------------
// btd_checker
// Port-level checks of the tone detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binary_tone_detector_dft_macros.svh"

module btd_checker (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic                     start_req,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic [btd_pkg::MAG_W-1:0] magnitude
);

  // A stalled result beat stays and keeps its value.
  `BTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(magnitude))

  // A start beat abandons the capture, so it never produces a new result.
  `BTD_ASSERT_IMPL(a_start_no_result, in_valid && in_ready && start_req, ##2 !$rose(out_valid))

  // Reset empties the output register.
  `BTD_ASSERT_NEXT_RST(a_reset_empty, rst, !out_valid)

  // The input side is never stalled while the output side is ready.
  `BTD_ASSERT_IMPL(a_no_false_stall, out_ready, in_ready)

endmodule

bind binary_tone_detector_dft btd_checker u_btd_checker (.*);

`default_nettype wire
